// ===== hdl/mvsb_pkg.sv =====
// Package for matvec_scale_bias: word types, opcodes, register indexes,
// sequencer states and fixed field widths.
// No dependencies.
`default_nettype none

package mvsb_pkg;

  localparam int DATA_W   = 16;
  localparam int ACC_W    = 48;
  localparam int IDX_W    = 6;
  localparam int VLEN_W   = 7;
  localparam int ROW_W    = 16;
  localparam int COEF_W   = 16;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W    = 16;

  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_MATRIX = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_VECTOR_LENGTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN          = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET        = 2'd3;

  typedef struct packed {
    logic                     opcode;
    logic signed [DATA_W-1:0] element_value;
    logic [IDX_W-1:0]         vector_index;
  } in_word_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] out_value;
    logic [ROW_W-1:0]         row_index;
    logic                     last_row;
  } out_word_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_ACC,
    ST_SCL_LO,
    ST_SCL_HI,
    ST_SAT
  } state_t;

endpackage

`default_nettype wire

// ===== hdl/mvsb_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Standalone; no package dependency.
`default_nettype none

module mvsb_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== hdl/matvec_scale_bias_top.sv =====
// Matrix-vector multiply with gain and offset, one word per handshake.
// Depends on mvsb_pkg and mvsb_ram.
//
// Usage:
//   Input words (in_valid/in_ready, in_data) either load one vector element
//   (opcode load, at vector_index) or carry one matrix element, row-major.
//   Each matrix element is multiplied by the stored vector element at the
//   running column and summed into a 48-bit accumulator. When a row is
//   complete the sum is scaled by gain, floored to Q8.8, offset is added and
//   the result is saturated; it leaves on out_valid/out_ready with its row
//   index and a last-row flag.
//   A matrix element passes through vector RAM read, multiply and accumulate;
//   a row-ending element goes on through scale-low and scale-high steps,
//   which build acc * gain from two partial products, then a saturate step.
//   The result shows on out_valid in the cycle after the saturate step.
//   The output register holds a finished result while the block takes
//   further words; only a second result waits in the saturate step until the
//   receiver takes the first. Reset (synchronous, rst_n low) clears counters,
//   accumulator and handshakes and sets the registers to length 1, rows 1,
//   gain 1.0, offset 0. The vector RAM is not cleared; read only entries
//   already loaded. The user writes configuration (cfg_we, cfg_index,
//   cfg_wdata) only while idle; the block itself does not enforce this.
`default_nettype none

module matvec_scale_bias_top #(
  parameter int MAX_VECTOR = 64
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire mvsb_pkg::in_word_t                 in_data,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output mvsb_pkg::out_word_t                     out_word,
  input  wire logic                               cfg_we,
  input  wire logic [mvsb_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [mvsb_pkg::CFG_W-1:0]         cfg_wdata
);

  localparam int AW = $clog2(MAX_VECTOR);
  localparam int CW = AW + 1;

  // configuration
  logic [mvsb_pkg::VLEN_W-1:0]        vlen_r;
  logic [mvsb_pkg::ROW_W-1:0]         rows_r;
  logic signed [mvsb_pkg::COEF_W-1:0] gain_r;
  logic signed [mvsb_pkg::COEF_W-1:0] offset_r;

  // control
  mvsb_pkg::state_t                   state_r, state_nxt;
  logic [AW-1:0]                      col_r, col_nxt;
  logic [mvsb_pkg::ROW_W-1:0]         row_r, row_nxt;
  logic signed [mvsb_pkg::ACC_W-1:0]  acc_r, acc_nxt;
  logic                               out_valid_r, out_valid_nxt;

  // datapath
  logic signed [mvsb_pkg::DATA_W-1:0] elem_r, elem_nxt;
  logic signed [2*mvsb_pkg::DATA_W-1:0] prod_r, prod_nxt;
  logic signed [mvsb_pkg::ACC_W-1:0]  snap_r, snap_nxt;
  logic [mvsb_pkg::ROW_W-1:0]         snap_row_r, snap_row_nxt;
  logic                               snap_last_r, snap_last_nxt;
  logic signed [63:0]                 tp_r, tp_nxt;
  mvsb_pkg::out_word_t                out_word_r, out_word_nxt;

  // RAM
  logic                               ram_we;
  logic [AW-1:0]                      ram_waddr;
  logic [AW-1:0]                      ram_raddr;
  logic                               ram_re;
  logic [mvsb_pkg::DATA_W-1:0]        ram_rdata;

  logic                               in_fire;
  logic [31:0]                        idx32;
  logic [31:0]                        len32;
  logic [CW-1:0]                      len_eff;
  logic [CW-1:0]                      col_inc;
  logic                               row_end;
  logic [mvsb_pkg::ROW_W:0]           rows_eff;
  logic [mvsb_pkg::ROW_W:0]           row_inc;
  logic                               row_last;
  logic signed [mvsb_pkg::ACC_W-1:0]  acc_sum;
  logic signed [40:0]                 lo_prod;
  logic signed [39:0]                 hi_prod;
  logic signed [48:0]                 biased;
  logic signed [mvsb_pkg::DATA_W-1:0] sat_val;

  assign in_ready  = (state_r == mvsb_pkg::ST_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  // vector load path
  assign idx32     = 32'(in_data.vector_index);
  assign ram_we    = in_fire && (in_data.opcode == mvsb_pkg::OP_LOAD) &&
                     (idx32 < 32'(MAX_VECTOR));
  assign ram_waddr = idx32[AW-1:0];
  assign ram_re    = in_fire && (in_data.opcode == mvsb_pkg::OP_MATRIX);
  assign ram_raddr = col_r;

  mvsb_ram #(
    .WIDTH (mvsb_pkg::DATA_W),
    .DEPTH (MAX_VECTOR)
  ) u_vec_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (in_data.element_value),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // clamp the row length to 1..MAX_VECTOR
  always_comb begin
    if (vlen_r == '0) begin
      len32 = 32'd1;
    end else if (32'(vlen_r) > 32'(MAX_VECTOR)) begin
      len32 = 32'(MAX_VECTOR);
    end else begin
      len32 = 32'(vlen_r);
    end
  end
  assign len_eff = len32[CW-1:0];
  assign col_inc = {1'b0, col_r} + CW'(1);
  assign row_end = (col_inc >= len_eff);

  assign rows_eff = (rows_r == '0) ? 17'd1 : {1'b0, rows_r};
  assign row_inc  = {1'b0, row_r} + 17'd1;
  assign row_last = (row_inc >= rows_eff);

  assign acc_sum = acc_r + {{(mvsb_pkg::ACC_W - 2*mvsb_pkg::DATA_W){prod_r[31]}}, prod_r};

  // acc * gain as two partial products: unsigned low 24 bits, signed high 24
  assign lo_prod = $signed({1'b0, snap_r[23:0]}) * gain_r;
  assign hi_prod = $signed(snap_r[47:24]) * gain_r;

  // floor shift by 16 is the upper bits; then add offset and saturate
  assign biased = $signed({tp_r[63], tp_r[63:16]}) +
                  $signed({{33{offset_r[15]}}, offset_r});
  always_comb begin
    if (biased > 49'sd32767) begin
      sat_val = 16'sh7fff;
    end else if (biased < -49'sd32768) begin
      sat_val = 16'sh8000;
    end else begin
      sat_val = biased[15:0];
    end
  end

  always_comb begin
    state_nxt     = state_r;
    col_nxt       = col_r;
    row_nxt       = row_r;
    acc_nxt       = acc_r;
    elem_nxt      = elem_r;
    prod_nxt      = prod_r;
    snap_nxt      = snap_r;
    snap_row_nxt  = snap_row_r;
    snap_last_nxt = snap_last_r;
    tp_nxt        = tp_r;
    out_word_nxt  = out_word_r;
    out_valid_nxt = out_valid_r && !out_ready;

    case (state_r)
      mvsb_pkg::ST_IDLE: begin
        if (in_fire && (in_data.opcode == mvsb_pkg::OP_MATRIX)) begin
          elem_nxt  = in_data.element_value;
          state_nxt = mvsb_pkg::ST_MUL;
        end
      end
      mvsb_pkg::ST_MUL: begin
        prod_nxt  = elem_r * $signed(ram_rdata);
        state_nxt = mvsb_pkg::ST_ACC;
      end
      mvsb_pkg::ST_ACC: begin
        if (row_end) begin
          snap_nxt      = acc_sum;
          snap_row_nxt  = row_r;
          snap_last_nxt = row_last;
          acc_nxt       = '0;
          col_nxt       = '0;
          row_nxt       = row_last ? '0 : row_inc[mvsb_pkg::ROW_W-1:0];
          state_nxt     = mvsb_pkg::ST_SCL_LO;
        end else begin
          acc_nxt   = acc_sum;
          col_nxt   = col_inc[AW-1:0];
          state_nxt = mvsb_pkg::ST_IDLE;
        end
      end
      mvsb_pkg::ST_SCL_LO: begin
        tp_nxt    = {{23{lo_prod[40]}}, lo_prod};
        state_nxt = mvsb_pkg::ST_SCL_HI;
      end
      mvsb_pkg::ST_SCL_HI: begin
        tp_nxt    = tp_r + {hi_prod, 24'd0};
        state_nxt = mvsb_pkg::ST_SAT;
      end
      mvsb_pkg::ST_SAT: begin
        // hold until the output register is free
        if (!out_valid_r || out_ready) begin
          out_word_nxt.out_value = sat_val;
          out_word_nxt.row_index = snap_row_r;
          out_word_nxt.last_row  = snap_last_r;
          out_valid_nxt          = 1'b1;
          state_nxt              = mvsb_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = mvsb_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mvsb_pkg::ST_IDLE;
      col_r       <= '0;
      row_r       <= '0;
      acc_r       <= '0;
      out_valid_r <= 1'b0;
      vlen_r      <= 7'd1;
      rows_r      <= 16'd1;
      gain_r      <= 16'sd256;
      offset_r    <= 16'sd0;
    end else begin
      state_r     <= state_nxt;
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      acc_r       <= acc_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          mvsb_pkg::CFG_VECTOR_LENGTH: vlen_r   <= cfg_wdata[mvsb_pkg::VLEN_W-1:0];
          mvsb_pkg::CFG_ROW_COUNT:     rows_r   <= cfg_wdata;
          mvsb_pkg::CFG_GAIN:          gain_r   <= $signed(cfg_wdata);
          mvsb_pkg::CFG_OFFSET:        offset_r <= $signed(cfg_wdata);
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    elem_r      <= elem_nxt;
    prod_r      <= prod_nxt;
    snap_r      <= snap_nxt;
    snap_row_r  <= snap_row_nxt;
    snap_last_r <= snap_last_nxt;
    tp_r        <= tp_nxt;
    out_word_r  <= out_word_nxt;
  end

endmodule

`default_nettype wire
